[rtl/core/lir_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lir_pkg: shared types and constants of the line raster core
// codes, controller states and the command / status groups
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int LIR_COORD_BITS = 10;
    localparam int LIR_FRAC_BITS  = 16;

    // word kinds on the input channel
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [1:0] {
        MODE_VERT  = 2'd0,
        MODE_RIGHT = 2'd1,
        MODE_LEFT  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_IMUL,
        ST_ISUB,
        ST_TADD,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic div_step;
        logic slope_set;
        logic mul;
        logic icept_set;
        logic tick_add;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic active;
        logic vert;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

[rtl/core/lir_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lir_if: channel interfaces of the line raster core
// valid / ready channels for command words and pixel words
// ----------------------------------------------------------------------------
interface lir_in_if #(
    parameter int COORD_BITS = lir_pkg::LIR_COORD_BITS
) ();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (output valid, kind, x_start, y_start, x_end, y_end, input ready);
    modport sink (input valid, kind, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lir_out_if #(
    parameter int COORD_BITS = lir_pkg::LIR_COORD_BITS
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last;

    modport source (output valid, pixel_x, pixel_y, last, input ready);
    modport sink (input valid, pixel_x, pixel_y, last, output ready);
endinterface
`default_nettype wire

[rtl/core/slope_intercept_line_raster_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slope_intercept_line_raster_core: slope-intercept line rasterizer
// start words set up one segment, tick words return its pixels in order
// ----------------------------------------------------------------------------
//
//  channel  | dir | word contents
//  ---------+-----+-------------------------------------------------
//  in_ch    | in  | kind (0 start, 1 tick), x_start, y_start, x_end, y_end
//  out_ch   | out | pixel_x, pixel_y, last
//
//  a start word runs the one-bit-per-cycle restoring slope divider, then the
//  slope sign and intercept steps; a vertical start skips the divider
//  a tick word steps through multiply, add, round/clamp into the output
//  register; a tick while no line is active is taken with no pixel
//  a new word is taken while a pixel waits in the output register; a tick
//  holds in its last step until out_ch frees that register
//  rst_n clears the sequencer, the line-active flag and the output valid
//
module slope_intercept_line_raster_core #(
    parameter int COORD_BITS = lir_pkg::LIR_COORD_BITS,
    parameter int FRAC_BITS  = lir_pkg::LIR_FRAC_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lir_in_if.sink    in_ch,
    lir_out_if.source out_ch
);
    import lir_pkg::*;

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: idle / divide / slope sign / intercept / tick steps
    lir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_kind  (in_ch.kind),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath: endpoints, divider, shared multiplier, output word register
    lir_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .x_start   (in_ch.x_start),
        .y_start   (in_ch.y_start),
        .x_end     (in_ch.x_end),
        .y_end     (in_ch.y_end),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .pixel_x   (out_ch.pixel_x),
        .pixel_y   (out_ch.pixel_y),
        .last      (out_ch.last)
    );

endmodule
`default_nettype wire

[rtl/core/lir_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lir_ctrl: sequencer of the line raster core
// steps line setup and pixel generation through the datapath
// ----------------------------------------------------------------------------
module lir_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_kind,
    output logic               in_ready,
    output lir_pkg::cmd_t      cmd,
    input  wire lir_pkg::sts_t sts
);
    import lir_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind == KIND_START)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else if (sts.active)
                    begin
                        cmd.mul    = 1'b1;
                        state_next = ST_TADD;
                    end
                end
            end
            ST_DIV:
            begin
                if (sts.vert)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (sts.div_last)
                    begin
                        state_next = ST_SIGN;
                    end
                end
            end
            ST_SIGN:
            begin
                cmd.slope_set = 1'b1;
                state_next    = ST_IMUL;
            end
            ST_IMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ISUB;
            end
            ST_ISUB:
            begin
                cmd.icept_set = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_TADD:
            begin
                cmd.tick_add = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/lir_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lir_dp: datapath of the line raster core
// slope divider, shared multiplier, intercept, pixel y and output register
// ----------------------------------------------------------------------------
module lir_dp #(
    parameter int COORD_BITS = lir_pkg::LIR_COORD_BITS,
    parameter int FRAC_BITS  = lir_pkg::LIR_FRAC_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lir_pkg::cmd_t         cmd,
    output lir_pkg::sts_t              sts,
    input  wire logic [COORD_BITS-1:0] x_start,
    input  wire logic [COORD_BITS-1:0] y_start,
    input  wire logic [COORD_BITS-1:0] x_end,
    input  wire logic [COORD_BITS-1:0] y_end,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [COORD_BITS-1:0]      pixel_x,
    output logic [COORD_BITS-1:0]      pixel_y,
    output logic                       last
);
    import lir_pkg::*;

    localparam int QW = COORD_BITS + FRAC_BITS;        // quotient magnitude
    localparam int SW = QW + 1;                        // signed slope
    localparam int IW = SW + COORD_BITS + 1;           // product and intercept
    localparam int VW = IW + 1;                        // y sum
    localparam int CW = $clog2(QW + 1);
    localparam logic signed [VW-1:0] HALF = VW'(1) << (FRAC_BITS - 1);

    // control state
    logic                  active_reg;
    mode_t                 mode_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  out_valid_reg;

    // payload
    logic [COORD_BITS-1:0] cur_reg;
    logic [COORD_BITS-1:0] final_reg;
    logic [COORD_BITS-1:0] fixed_x_reg;
    logic [COORD_BITS-1:0] y1_reg;
    logic [COORD_BITS-1:0] dvs_reg;
    logic [COORD_BITS-1:0] rem_reg;
    logic [QW-1:0]         quo_reg;
    logic                  neg_reg;
    logic signed [SW-1:0]  slope_reg;
    logic signed [IW-1:0]  icept_reg;
    logic signed [IW-1:0]  prod_reg;
    logic signed [VW-1:0]  v_reg;
    logic [COORD_BITS-1:0] px_reg;
    logic [COORD_BITS-1:0] py_reg;
    logic                  last_reg;

    logic                  is_vert;
    logic [COORD_BITS-1:0] dx_mag;
    logic [COORD_BITS-1:0] dy_mag;
    logic [COORD_BITS:0]   rem_shift;
    logic                  rem_ge;
    logic [COORD_BITS:0]   rem_diff;
    logic signed [SW-1:0]  quo_s;
    logic signed [IW-1:0]  prod_next;
    logic signed [IW-1:0]  y1_fix;
    logic signed [VW-1:0]  v_next;
    logic signed [VW-1:0]  r_full;
    logic [COORD_BITS-1:0] y_clamp;
    logic                  is_last;
    logic                  out_free;

    always_comb
    begin
        is_vert   = (x_start == x_end);
        dx_mag    = (x_end > x_start) ? (x_end - x_start) : (x_start - x_end);
        dy_mag    = (y_end > y_start) ? (y_end - y_start) : (y_start - y_end);

        // one restoring division step
        rem_shift = {rem_reg, quo_reg[QW-1]};
        rem_ge    = (rem_shift >= {1'b0, dvs_reg});
        rem_diff  = rem_shift - {1'b0, dvs_reg};

        quo_s     = $signed({1'b0, quo_reg});
        prod_next = slope_reg * $signed({1'b0, cur_reg});
        y1_fix    = $signed(IW'({y1_reg, {FRAC_BITS{1'b0}}}));
        v_next    = VW'(prod_reg) + VW'(icept_reg) + HALF;

        // round to nearest and clamp
        r_full    = v_reg >>> FRAC_BITS;
        if (r_full[VW-1])
        begin
            y_clamp = '0;
        end
        else if (r_full[VW-2:COORD_BITS] != '0)
        begin
            y_clamp = '1;
        end
        else
        begin
            y_clamp = r_full[COORD_BITS-1:0];
        end

        is_last   = (cur_reg == final_reg);
        out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            mode_reg      <= MODE_VERT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= CW'(QW);
                if (is_vert)
                begin
                    mode_reg <= MODE_VERT;
                end
                else if (x_end > x_start)
                begin
                    mode_reg <= MODE_RIGHT;
                end
                else
                begin
                    mode_reg <= MODE_LEFT;
                end
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (is_last)
                begin
                    active_reg <= 1'b0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            y1_reg   <= y_start;
            dvs_reg  <= dx_mag;
            rem_reg  <= '0;
            quo_reg  <= {dy_mag, {FRAC_BITS{1'b0}}};
            neg_reg  <= (y_end < y_start) ^ (x_end < x_start);
            slope_reg <= '0;
            icept_reg <= '0;
            if (is_vert)
            begin
                fixed_x_reg <= x_start;
                cur_reg     <= (y_start < y_end) ? y_start : y_end;
                final_reg   <= (y_start < y_end) ? y_end : y_start;
            end
            else
            begin
                fixed_x_reg <= '0;
                cur_reg     <= x_start;
                final_reg   <= x_end;
            end
        end
        else if (cmd.emit && !is_last)
        begin
            if (mode_reg == MODE_LEFT)
            begin
                cur_reg <= cur_reg - COORD_BITS'(1);
            end
            else
            begin
                cur_reg <= cur_reg + COORD_BITS'(1);
            end
        end

        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_diff[COORD_BITS-1:0] : rem_shift[COORD_BITS-1:0];
            quo_reg <= {quo_reg[QW-2:0], rem_ge};
        end

        if (cmd.slope_set)
        begin
            slope_reg <= neg_reg ? -quo_s : quo_s;
        end

        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end

        if (cmd.icept_set)
        begin
            icept_reg <= y1_fix - prod_reg;
        end

        if (cmd.tick_add)
        begin
            v_reg <= v_next;
        end

        if (cmd.emit)
        begin
            last_reg <= is_last;
            if (mode_reg == MODE_VERT)
            begin
                px_reg <= fixed_x_reg;
                py_reg <= cur_reg;
            end
            else
            begin
                px_reg <= cur_reg;
                py_reg <= y_clamp;
            end
        end
    end

    always_comb
    begin
        sts.active   = active_reg;
        sts.vert     = (mode_reg == MODE_VERT);
        sts.div_last = (cnt_reg == CW'(1));
        sts.out_free = out_free;
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = px_reg;
    assign pixel_y   = py_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire

[dv/slope_intercept_line_raster_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slope_intercept_line_raster_core_tb: self-checking bench of the line raster
// start and tick words go in over in_ch; an in-bench line tracer predicts
// every pixel word, and each pixel taken from out_ch is checked in order
// ----------------------------------------------------------------------------
module slope_intercept_line_raster_core_tb;

    import lir_pkg::*;

    localparam int CB = LIR_COORD_BITS;
    localparam int FB = LIR_FRAC_BITS;
    localparam logic [CB-1:0] COORD_MAX = '1;

    localparam int TOTAL_WORDS  = 1175;   // directed words plus about 1150 random
    localparam int STALL_LIMIT  = 5000;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 40;     // must outlast the setup of a start word
    localparam int HOLD_CYCLES  = 400;    // long pixel back-pressure stretch
    localparam int HOLD_AFTER   = 150;    // pixels seen before the stretch starts

    typedef struct {
        logic          kind;
        logic [CB-1:0] x_start;
        logic [CB-1:0] y_start;
        logic [CB-1:0] x_end;
        logic [CB-1:0] y_end;
    } cmd_word_t;

    typedef struct {
        logic [CB-1:0] pixel_x;
        logic [CB-1:0] pixel_y;
        logic          last;
    } pixel_word_t;

    logic clk = 1'b0;
    logic rst_n;

    lir_in_if  #(.COORD_BITS(CB)) in_ch ();
    lir_out_if #(.COORD_BITS(CB)) out_ch ();

    slope_intercept_line_raster_core #(
        .COORD_BITS (CB),
        .FRAC_BITS  (FB)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    // words waiting to be sent, pixels waiting to come back
    cmd_word_t   cmd_q[$];
    pixel_word_t pixel_q[$];
    cmd_word_t   word_on_bus;

    // traced line, mirrors what the core should hold
    logic          ln_active = 1'b0;
    mode_t         ln_mode   = MODE_VERT;
    logic [CB-1:0] ln_cur    = '0;
    logic [CB-1:0] ln_final  = '0;
    logic [CB-1:0] ln_fixed_x = '0;
    longint        ln_slope  = 0;
    longint        ln_icept  = 0;

    int unsigned cyc = 0;
    int unsigned stall_cycles = 0;
    int unsigned pixels_seen = 0;
    int unsigned hold_left = 0;
    bit          held_once = 1'b0;
    int unsigned mismatches = 0;

    // quiet window: neither side idles here
    wire calm = (cyc >= 3000) && (cyc < 6000);

    // ------------------------------------------------------------------------
    // line tracer
    // ------------------------------------------------------------------------

    // y = m*x + b, rounded half up (floor of v + 1/2), clamped to the grid
    function automatic logic [CB-1:0] round_y(logic [CB-1:0] x);
        longint v;
        longint r;
        v = ln_slope * longint'(x) + ln_icept + (longint'(1) <<< (FB - 1));
        r = v >>> FB;
        if (r < 0)
            return '0;
        if (r > longint'(COORD_MAX))
            return COORD_MAX;
        return r[CB-1:0];
    endfunction

    // apply one accepted word to the traced line, queue the pixel it gives
    function automatic void advance_line(cmd_word_t w);
        pixel_word_t px;
        longint      dx;
        longint      dy;
        if (w.kind == KIND_START) begin
            // a new start simply drops any line still in progress
            ln_active = 1'b1;
            if (w.x_start == w.x_end) begin
                // vertical, and single points too: walk y upward at fixed x
                ln_mode    = MODE_VERT;
                ln_fixed_x = w.x_start;
                ln_cur     = (w.y_start < w.y_end) ? w.y_start : w.y_end;
                ln_final   = (w.y_start < w.y_end) ? w.y_end : w.y_start;
                ln_slope   = 0;
                ln_icept   = 0;
            end
            else begin
                dy = longint'(w.y_end) - longint'(w.y_start);
                dx = longint'(w.x_end) - longint'(w.x_start);
                // signed divide truncates toward zero, the intercept is exact
                ln_slope   = (dy * (longint'(1) <<< FB)) / dx;
                ln_icept   = longint'(w.y_start) * (longint'(1) <<< FB)
                             - ln_slope * longint'(w.x_start);
                ln_mode    = (w.x_end > w.x_start) ? MODE_RIGHT : MODE_LEFT;
                ln_fixed_x = '0;
                ln_cur     = w.x_start;
                ln_final   = w.x_end;
            end
        end
        else if (ln_active) begin
            // a tick with no line in progress gives nothing
            px.last = (ln_cur == ln_final);
            if (ln_mode == MODE_VERT) begin
                px.pixel_x = ln_fixed_x;
                px.pixel_y = ln_cur;
            end
            else begin
                px.pixel_x = ln_cur;
                px.pixel_y = round_y(ln_cur);
            end
            pixel_q.push_back(px);
            if (px.last)
                ln_active = 1'b0;
            else if (ln_mode == MODE_LEFT)
                ln_cur = ln_cur - CB'(1);
            else
                ln_cur = ln_cur + CB'(1);
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > int'(COORD_MAX))
            return int'(COORD_MAX);
        return v;
    endfunction

    task automatic push_start(int xs, int ys, int xe, int ye);
        cmd_word_t w;
        w.kind    = KIND_START;
        w.x_start = xs[CB-1:0];
        w.y_start = ys[CB-1:0];
        w.x_end   = xe[CB-1:0];
        w.y_end   = ye[CB-1:0];
        cmd_q.push_back(w);
    endtask

    // coordinates of a tick are don't-care, so they carry random junk
    task automatic push_ticks(int n);
        cmd_word_t w;
        repeat (n)
        begin
            w.kind    = KIND_TICK;
            w.x_start = CB'($urandom());
            w.y_start = CB'($urandom());
            w.x_end   = CB'($urandom());
            w.y_end   = CB'($urandom());
            cmd_q.push_back(w);
        end
    endtask

    task automatic flag_mismatch(string what, int got, int want);
        $display("ERROR at %0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // command driver: holds a word until taken, idles now and then
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            // the word on the bus is taken at this edge: trace it
            if (in_ch.valid && in_ch.ready)
                advance_line(word_on_bus);
            // only change the bus once the current word is gone
            if (!in_ch.valid || in_ch.ready)
            begin
                if (cmd_q.size() != 0 && (calm || $urandom_range(0, 99) >= 24))
                begin
                    word_on_bus = cmd_q.pop_front();
                    in_ch.kind    <= word_on_bus.kind;
                    in_ch.x_start <= word_on_bus.x_start;
                    in_ch.y_start <= word_on_bus.y_start;
                    in_ch.x_end   <= word_on_bus.x_end;
                    in_ch.y_end   <= word_on_bus.y_end;
                    in_ch.valid   <= 1'b1;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // pixel monitor: checks each taken pixel, throttles ready
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                pixels_seen++;
                if (pixel_q.size() == 0)
                begin
                    flag_mismatch("pixel with none expected, pixel_x",
                                  int'(out_ch.pixel_x), -1);
                end
                else
                begin
                    pixel_word_t want;
                    want = pixel_q.pop_front();
                    if (out_ch.pixel_x !== want.pixel_x)
                        flag_mismatch("pixel_x", int'(out_ch.pixel_x), int'(want.pixel_x));
                    if (out_ch.pixel_y !== want.pixel_y)
                        flag_mismatch("pixel_y", int'(out_ch.pixel_y), int'(want.pixel_y));
                    if (out_ch.last !== want.last)
                        flag_mismatch("last", int'(out_ch.last), int'(want.last));
                end
            end
            // one long hold-off so the output register fills and in_ch backs up
            if (!held_once && pixels_seen >= HOLD_AFTER)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= calm || ($urandom_range(0, 99) >= 24);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cyc <= cyc + 1;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("slope_intercept_line_raster_core verification failed");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int xa;
        int ya;
        int xb;
        int yb;
        int sel;
        int shape;
        int npix;

        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = KIND_TICK;
        in_ch.x_start = '0;
        in_ch.y_start = '0;
        in_ch.x_end   = '0;
        in_ch.y_end   = '0;
        out_ch.ready  = 1'b0;

        // directed part
        push_ticks(1);                          // tick before any line
        push_start(1000, 5, 1000, 5);           // single point
        push_ticks(2);                          // second tick finds the line done
        push_start(7, 20, 7, 17);               // vertical given top first
        push_ticks(4);
        push_start(1023, 1023, 1020, 1023);     // horizontal, leftward
        push_ticks(4);
        push_start(0, 0, 2, 1023);              // very steep, edges of the grid
        push_ticks(3);
        push_start(0, 1023, 1023, 0);           // full diagonal, cut short
        push_ticks(2);
        push_start(1023, 0, 1021, 1023);        // restart mid-line, steep leftward
        push_ticks(3);

        // random part: mostly whole short lines anywhere on the grid
        while (cmd_q.size() < TOTAL_WORDS)
        begin
            sel   = $urandom_range(0, 99);
            shape = $urandom_range(0, 3);
            xa    = $urandom_range(0, int'(COORD_MAX));
            ya    = $urandom_range(0, int'(COORD_MAX));
            if (sel >= 78 && sel < 88)
            begin
                // arbitrary segment, any slope, usually abandoned early
                xb = $urandom_range(0, int'(COORD_MAX));
                yb = $urandom_range(0, int'(COORD_MAX));
            end
            else if (shape == 0)
            begin
                xb = xa;
                yb = clamp_coord(ya + $urandom_range(0, 16) - 8);
            end
            else if (shape == 1)
            begin
                xb = clamp_coord(xa + $urandom_range(0, 16) - 8);
                yb = ya;
            end
            else
            begin
                xb = clamp_coord(xa + $urandom_range(0, 24) - 12);
                yb = clamp_coord(ya + $urandom_range(0, 80) - 40);
            end
            npix = (xa == xb) ? ((ya > yb) ? ya - yb : yb - ya) + 1
                              : ((xa > xb) ? xa - xb : xb - xa) + 1;
            if (sel < 78)
            begin
                // well formed, sometimes with spare ticks after the end
                push_start(xa, ya, xb, yb);
                push_ticks(npix + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0));
            end
            else if (sel < 88)
            begin
                push_start(xa, ya, xb, yb);
                push_ticks((npix < 20) ? npix : $urandom_range(1, 20));
            end
            else if (sel < 94)
            begin
                // broken: restarted before the end
                push_start(xa, ya, xb, yb);
                push_ticks($urandom_range(0, 3));
            end
            else
            begin
                push_ticks($urandom_range(1, 3));
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // all words sent, then all pixels back, then let the core settle
        while (cmd_q.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pixel_q.size() == 0)
            $display("slope_intercept_line_raster_core verification clean");
        else
            $display("slope_intercept_line_raster_core verification failed");
        $finish;
    end

endmodule
